// ===== sv/assert_macros.svh =====
// Assertion macros for the checker of the bounded step accumulator.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BSA_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("%m: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define BSA_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("%m: next-cycle check failed");

`endif

// ===== sv/bsa_pkg.sv =====
// Package of the bounded step accumulator: widths, register indexes and the
// structs passed between the sequencer, the register file and the divider.
package bsa_pkg;

  localparam int ValW     = 16;               // accumulator, bounds, step, move
  localparam int SumW     = 32;               // sum, dividend, wrap amount
  localparam int SpanW    = 17;               // span of the bounds, divisor, remainder
  localparam int CntW     = $clog2(SumW);     // divider step counter
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 16;

  localparam logic [CfgIdxW-1:0] RegLower = 2'd0;
  localparam logic [CfgIdxW-1:0] RegUpper = 2'd1;
  localparam logic [CfgIdxW-1:0] RegStep  = 2'd2;
  localparam logic [CfgIdxW-1:0] RegWrap  = 2'd3;

  typedef struct packed {
    logic signed [ValW-1:0] lower;
    logic signed [ValW-1:0] upper;
    logic signed [ValW-1:0] step;
    logic                   wrap;
  } cfg_t;

  typedef struct packed {
    logic             start;
    logic [SumW-1:0]  dividend;
    logic [SpanW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [SpanW-1:0] remainder;
  } div_rsp_t;

endpackage

// ===== sv/bsa_if.sv =====
// Channel interfaces of the bounded step accumulator: move input, result
// output and configuration write. Depends on bsa_pkg.
interface bsa_move_if import bsa_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic signed [ValW-1:0] move_amount;
  modport source (output valid, move_amount, input ready);
  modport sink   (input valid, move_amount, output ready);
endinterface

interface bsa_result_if import bsa_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic signed [ValW-1:0] current_value;
  logic signed [SumW-1:0] wrap_amount;
  logic                   wrap_valid;
  modport source (output valid, current_value, wrap_amount, wrap_valid, input ready);
  modport sink   (input valid, current_value, wrap_amount, wrap_valid, output ready);
endinterface

interface bsa_cfg_if import bsa_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  index;
  logic [CfgDataW-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== sv/bsa_divider.sv =====
// Iterative restoring divider of the bounded step accumulator: one quotient
// bit per cycle, returns the remainder only. Depends on bsa_pkg.
module bsa_divider import bsa_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  logic [SumW-1:0]  dvd_q;
  logic [SpanW-1:0] rem_q, rem_d;
  logic [SpanW-1:0] dsr_q;
  logic [CntW-1:0]  cnt_q;
  logic             busy_q, done_q;

  logic [SpanW:0] trial, diff;
  logic           borrow;

  always_comb begin
    trial  = {rem_q, dvd_q[SumW-1]};
    diff   = trial - {1'b0, dsr_q};
    borrow = trial < {1'b0, dsr_q};
    // restore on borrow; the partial remainder stays below the divisor
    rem_d  = borrow ? trial[SpanW-1:0] : diff[SpanW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (req_i.start) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 1'b1;
      if (cnt_q == CntW'(SumW - 1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      dvd_q <= req_i.dividend;
      dsr_q <= req_i.divisor;
      rem_q <= '0;
    end else if (busy_q) begin
      dvd_q <= {dvd_q[SumW-2:0], 1'b0};
      rem_q <= rem_d;
    end
  end

  assign rsp_o.done      = done_q;
  assign rsp_o.remainder = rem_q;

endmodule

// ===== sv/bsa_cfg_regs.sv =====
// Configuration register file of the bounded step accumulator: bounds, step
// and wrap mode, written through the config channel. Depends on bsa_pkg, bsa_if.
module bsa_cfg_regs import bsa_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  bsa_cfg_if.sink cfg_i,
  output cfg_t  cfg_o
);

  cfg_t cfg_q;

  // always take a write
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.lower <= 16'sd0;
      cfg_q.upper <= 16'sd1;
      cfg_q.step  <= 16'sd1;
      cfg_q.wrap  <= 1'b0;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        RegLower: cfg_q.lower <= $signed(cfg_i.data[ValW-1:0]);
        RegUpper: cfg_q.upper <= $signed(cfg_i.data[ValW-1:0]);
        RegStep:  cfg_q.step  <= $signed(cfg_i.data[ValW-1:0]);
        RegWrap:  cfg_q.wrap  <= cfg_i.data[0];
        default:  cfg_q       <= cfg_q;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== sv/bounded_step_accumulator_unit.sv =====
// Bounded step accumulator, top level. Depends on bsa_pkg, bsa_if,
// bsa_cfg_regs and bsa_divider.
//
// Usage:
//   move_i   - valid/ready channel carrying a signed 16-bit move count. Each
//              transaction adds step_size * move_amount to the kept value.
//   result_o - valid/ready channel; one transaction per move: the new value,
//              the wrap amount and the wrap/clamp flag.
//   cfg_i    - write channel (index, data), always ready. Index 0 lower bound,
//              1 upper bound, 2 step size, 3 wrap enable. Write only while idle.
// Timing: a move is taken only when the sequencer is idle. Saturating moves,
//   and wrapping moves that land inside the bounds, pass through the sum,
//   decide and done states before the result is registered. A move that wraps
//   also runs the 32-step iterative divider and the fix state. A new move is
//   accepted only after the previous result has left the sequencer for the
//   output register.
// Reset: bounds 0..1, step 1, saturate mode, kept value 0, channels empty.
// Stall: a finished result sits in the output register; the next move can be
//   accepted and processed meanwhile, and its result waits in the sequencer
//   until the output register frees up.
module bounded_step_accumulator_unit import bsa_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  bsa_move_if.sink     move_i,
  bsa_result_if.source result_o,
  bsa_cfg_if.sink      cfg_i
);

  // sequencer codes
  localparam logic [2:0] SIdle   = 3'd0;
  localparam logic [2:0] SSum    = 3'd1;
  localparam logic [2:0] SDecide = 3'd2;
  localparam logic [2:0] SDiv    = 3'd3;
  localparam logic [2:0] SFix    = 3'd4;
  localparam logic [2:0] SDone   = 3'd5;

  cfg_t     cfg;
  div_req_t div_req;
  div_rsp_t div_rsp;

  logic [2:0]             state_q, state_d;
  logic signed [ValW-1:0] acc_q;
  logic signed [SumW-1:0] mul_q;
  logic signed [SumW-1:0] sum_q;
  logic [SumW-1:0]        num_q;
  logic [SumW-1:0]        mag_q;
  logic                   down_q;
  logic signed [ValW-1:0] new_val_q;
  logic signed [SumW-1:0] shift_q;
  logic                   flag_q;

  logic                   out_valid_q;
  logic signed [ValW-1:0] out_val_q;
  logic signed [SumW-1:0] out_shift_q;
  logic                   out_flag_q;

  bsa_cfg_regs u_cfg_regs (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  bsa_divider u_divider (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // bounds, sign-extended to the sum width
  logic signed [SumW-1:0] lo_ext, hi_ext;
  logic                   wrap_ok, above, below, bound_inv, below_after;
  logic                   move_acc, out_free;

  assign lo_ext   = SumW'(cfg.lower);
  assign hi_ext   = SumW'(cfg.upper);
  assign move_acc = move_i.valid && move_i.ready;
  assign out_free = !out_valid_q || result_o.ready;

  always_comb begin
    bound_inv   = cfg.upper < cfg.lower;
    wrap_ok     = cfg.wrap && (cfg.upper > cfg.lower);
    above       = sum_q > hi_ext;
    below       = sum_q < lo_ext;
    // after a clamp to upper, the lower clamp hits only when bounds are inverted
    below_after = above ? bound_inv : below;
  end

  // divider request: ceil(d / span) * span, d the distance beyond the bound, equals
  // n - (n mod span) with n = v - lo - 1 above the range, or n = hi - v - 1 below it
  logic [SpanW-1:0] span_w;
  always_comb begin
    span_w           = {cfg.upper[ValW-1], cfg.upper} - {cfg.lower[ValW-1], cfg.lower};
    div_req.start    = (state_q == SDecide) && wrap_ok && (above || below);
    div_req.divisor  = span_w;
    div_req.dividend = above ? SumW'(sum_q + ~lo_ext) : SumW'(hi_ext + ~sum_q);
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      SIdle:   if (move_acc) state_d = SSum;
      SSum:    state_d = SDecide;
      SDecide: state_d = div_req.start ? SDiv : SDone;
      SDiv:    if (div_rsp.done) state_d = SFix;
      SFix:    state_d = SDone;
      SDone:   if (out_free) state_d = SIdle;
      default: state_d = SIdle;
    endcase
  end

  assign move_i.ready = (state_q == SIdle);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SIdle;
      acc_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == SDone && out_free) begin
        acc_q       <= new_val_q;
        out_valid_q <= 1'b1;
      end else if (result_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // datapath: multiply, add, then either clamp or wrap through the divider
  always_ff @(posedge clk_i) begin
    if (move_acc) begin
      mul_q <= SumW'(cfg.step) * SumW'(move_i.move_amount);
    end
    if (state_q == SSum) begin
      sum_q <= SumW'(acc_q) + mul_q;
    end
    if (state_q == SDecide) begin
      num_q  <= div_req.dividend;
      down_q <= above;
      if (!div_req.start) begin
        shift_q <= '0;
        flag_q  <= above || below_after;
        if (below_after) begin
          new_val_q <= cfg.lower;
        end else if (above) begin
          new_val_q <= cfg.upper;
        end else begin
          new_val_q <= sum_q[ValW-1:0];
        end
      end
    end
    if (state_q == SDiv && div_rsp.done) begin
      mag_q <= num_q - SumW'(div_rsp.remainder);
    end
    if (state_q == SFix) begin
      flag_q <= 1'b1;
      if (down_q) begin
        shift_q   <= -$signed(mag_q);
        new_val_q <= sum_q[ValW-1:0] - mag_q[ValW-1:0];
      end else begin
        shift_q   <= $signed(mag_q);
        new_val_q <= sum_q[ValW-1:0] + mag_q[ValW-1:0];
      end
    end
    if (state_q == SDone && out_free) begin
      out_val_q   <= new_val_q;
      out_shift_q <= shift_q;
      out_flag_q  <= flag_q;
    end
  end

  assign result_o.valid         = out_valid_q;
  assign result_o.current_value = out_val_q;
  assign result_o.wrap_amount   = out_shift_q;
  assign result_o.wrap_valid    = out_flag_q;

endmodule

// ===== sv/bsa_checker.sv =====
// Port-level checker of the bounded step accumulator, bound to the top level.
// Depends on bsa_pkg and assert_macros.svh.
`include "assert_macros.svh"

module bsa_checker import bsa_pkg::*; (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   move_valid_i,
  input logic                   move_ready_i,
  input logic                   res_valid_i,
  input logic                   res_ready_i,
  input logic signed [ValW-1:0] res_value_i,
  input logic signed [SumW-1:0] res_shift_i,
  input logic                   res_flag_i
);

  logic res_stall;
  assign res_stall = res_valid_i && !res_ready_i;

  // a stalled result stays offered
  `BSA_ASSERT_NXT(a_res_hold_valid, clk_i, rst_ni, res_stall, res_valid_i)
  // and keeps its payload
  `BSA_ASSERT_NXT(a_res_hold_data, clk_i, rst_ni, res_stall, $stable(res_value_i) && $stable(res_shift_i) && $stable(res_flag_i))
  // one move at a time: busy right after an accepted move
  `BSA_ASSERT_NXT(a_busy_after_move, clk_i, rst_ni, move_valid_i && move_ready_i, !move_ready_i)
  // a shift is only reported together with the wrap flag
  `BSA_ASSERT_IMP(a_shift_needs_flag, clk_i, rst_ni, res_valid_i && !res_flag_i, res_shift_i == '0)

endmodule

bind bounded_step_accumulator_unit bsa_checker u_bsa_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .move_valid_i (move_i.valid),
  .move_ready_i (move_i.ready),
  .res_valid_i  (result_o.valid),
  .res_ready_i  (result_o.ready),
  .res_value_i  (result_o.current_value),
  .res_shift_i  (result_o.wrap_amount),
  .res_flag_i   (result_o.wrap_valid)
);
